### src/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types and constants of the terminal key sequence decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ESC    = 4'd1,
    PH_SEQ1   = 4'd2,
    PH_SEQ2   = 4'd3,
    PH_PASTE3 = 4'd4,
    PH_PASTE4 = 4'd5,
    PH_MOD    = 4'd6,
    PH_DIR    = 4'd7
  } phase_e;

  // Key codes.
  localparam logic [4:0] K_PLAIN    = 5'd0;
  localparam logic [4:0] K_ESC      = 5'd1;
  localparam logic [4:0] K_BS       = 5'd2;
  localparam logic [4:0] K_ALTBS    = 5'd3;
  localparam logic [4:0] K_CTRL_R   = 5'd4;
  localparam logic [4:0] K_CTRL_F   = 5'd5;
  localparam logic [4:0] K_CTRL_G   = 5'd6;
  localparam logic [4:0] K_CTRL_C   = 5'd7;
  localparam logic [4:0] K_CTRL_X   = 5'd8;
  localparam logic [4:0] K_CTRL_V   = 5'd9;
  localparam logic [4:0] K_CTRL_Z   = 5'd10;
  localparam logic [4:0] K_CTRL_W   = 5'd11;
  localparam logic [4:0] K_UP       = 5'd12;
  localparam logic [4:0] K_DELETE   = 5'd16;
  localparam logic [4:0] K_PSTART   = 5'd17;
  localparam logic [4:0] K_PEND     = 5'd18;
  localparam logic [4:0] K_CTRL_UP  = 5'd19;
  localparam logic [4:0] K_SHIFT_UP = 5'd23;
  localparam logic [4:0] K_CS_RIGHT = 5'd27;
  localparam logic [4:0] K_CS_LEFT  = 5'd28;
  localparam logic [4:0] K_MAX      = 5'd28;

  // Operation kinds.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Bytes of interest.
  localparam logic [7:0] B_CTRL_R = 8'd18;
  localparam logic [7:0] B_CTRL_F = 8'd6;
  localparam logic [7:0] B_CTRL_G = 8'd7;
  localparam logic [7:0] B_CTRL_C = 8'd3;
  localparam logic [7:0] B_CTRL_X = 8'd24;
  localparam logic [7:0] B_CTRL_V = 8'd22;
  localparam logic [7:0] B_CTRL_Z = 8'd26;
  localparam logic [7:0] B_CTRL_W = 8'd23;
  localparam logic [7:0] B_ESC    = 8'd27;
  localparam logic [7:0] B_DEL    = 8'h7F;
  localparam logic [7:0] B_BS     = 8'h08;
  localparam logic [7:0] B_TILDE  = 8'h7E;
  localparam logic [7:0] B_LBRACK = 8'h5B;
  localparam logic [7:0] B_SEMI   = 8'h3B;
  localparam logic [7:0] B_DIG0   = 8'h30;
  localparam logic [7:0] B_DIG1   = 8'h31;
  localparam logic [7:0] B_DIG2   = 8'h32;
  localparam logic [7:0] B_DIG3   = 8'h33;
  localparam logic [7:0] B_DIG5   = 8'h35;
  localparam logic [7:0] B_DIG6   = 8'h36;
  localparam logic [7:0] B_DIG9   = 8'h39;
  localparam logic [7:0] B_UPA    = 8'h41;
  localparam logic [7:0] B_UPD    = 8'h44;

  typedef struct packed {
    logic       valid;
    logic [4:0] code;
    logic [7:0] ch;
  } result_t;

endpackage

### src/terminal_key_sequence_decoder.sv
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Decodes terminal keyboard bytes and escape timeout ticks into key codes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per transfer: tdata holds the received
//   byte and tuser[0] says whether the item is a byte (0) or an escape
//   timeout tick (1). The master stream carries one key code per transfer.
//   An item yields zero or one result; bytes that open or continue an
//   escape sequence, and ticks outside a lone ESC, yield none.
//   An accepted item is captured in the input register and decoded there;
//   its result is loaded into the result register once that register is
//   free, and the master side presents it from the result register.
//   Throughput: one item per cycle while the result register is free, set by
//   the single-pass decode between the input register and the result register.
//   When the receiver stalls, the result register holds its key code and
//   the input register holds the next item; s_axis_tready drops once both
//   are full and returns in the cycle that m_axis_tready rises.
//   Reset clears the parse state to idle and empties both registers.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,  // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [4:0] key_code, [12:5] char_value, zero pad
);
  import tksd_pkg::*;

  logic       in_valid_q;
  logic       in_op_q;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       advance;
  result_t    res;
  logic [4:0] key_code;
  logic [7:0] char_value;

  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata;
    end
  end

  tksd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .op_i      (in_op_q),
    .byte_i    (in_byte_q),
    .res_o     (res)
  );

  tksd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .code_o  (key_code),
    .ch_o    (char_value)
  );

  assign m_axis_tdata = {3'b000, char_value, key_code};

`ifndef NO_ASSERTIONS
  // An empty input register must always take a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  // Only a plain character carries a character byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && key_code != K_PLAIN) |-> (char_value == 8'd0))
    else $error("character byte set on a non-plain key");

  // Key codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (key_code <= K_MAX))
    else $error("key code out of range");

  // A decoded result lands in the result register in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.valid) |=> m_axis_tvalid)
    else $error("decoded result lost");
`endif

endmodule

### src/tksd_decode.sv
// ----------------------------------------------------------------------------
// tksd_decode
// Parse state and single-pass decode of one registered input item.
// ----------------------------------------------------------------------------
module tksd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              op_i,
  input  logic [7:0]        byte_i,
  output tksd_pkg::result_t res_o
);
  import tksd_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       dir_ok;
  logic [4:0] dir_off;
  logic       is_digit;

  assign dir_ok   = (byte_i >= B_UPA) && (byte_i <= B_UPD);
  assign dir_off  = {3'b000, byte_i[1:0] - 2'd1};
  assign is_digit = (byte_i >= B_DIG0) && (byte_i <= B_DIG9);

  always_comb begin
    phase_d   = phase_q;
    held_d    = held_q;
    res_o     = '0;
    if (op_i == OP_TICK) begin
      if (phase_q == PH_ESC) begin
        phase_d    = PH_IDLE;
        res_o.valid = 1'b1;
        res_o.code  = K_ESC;
      end
    end else begin
      case (phase_q)
        PH_ESC: begin
          if (byte_i == B_DEL || byte_i == B_BS) begin
            phase_d     = PH_IDLE;
            res_o.valid = 1'b1;
            res_o.code  = K_ALTBS;
          end else begin
            held_d  = byte_i;
            phase_d = PH_SEQ1;
          end
        end
        PH_SEQ1: begin
          phase_d     = PH_IDLE;
          res_o.valid = 1'b1;
          res_o.code  = K_ESC;
          if (held_q == B_LBRACK) begin
            if (dir_ok) begin
              res_o.code = K_UP + dir_off;
            end else if (is_digit) begin
              held_d      = byte_i;
              phase_d     = PH_SEQ2;
              res_o.valid = 1'b0;
            end
          end
        end
        PH_SEQ2: begin
          phase_d     = PH_IDLE;
          res_o.valid = 1'b1;
          res_o.code  = K_ESC;
          if (held_q == B_DIG3 && byte_i == B_TILDE) begin
            res_o.code = K_DELETE;
          end else if (held_q == B_DIG2 && byte_i == B_DIG0) begin
            phase_d     = PH_PASTE3;
            res_o.valid = 1'b0;
          end else if (held_q == B_DIG1 && byte_i == B_SEMI) begin
            phase_d     = PH_MOD;
            res_o.valid = 1'b0;
          end
        end
        PH_PASTE3: begin
          held_d  = byte_i;
          phase_d = PH_PASTE4;
        end
        PH_PASTE4: begin
          phase_d     = PH_IDLE;
          res_o.valid = 1'b1;
          res_o.code  = K_ESC;
          if (byte_i == B_TILDE && held_q == B_DIG0) begin
            res_o.code = K_PSTART;
          end else if (byte_i == B_TILDE && held_q == B_DIG1) begin
            res_o.code = K_PEND;
          end
        end
        PH_MOD: begin
          held_d  = byte_i;
          phase_d = PH_DIR;
        end
        PH_DIR: begin
          phase_d     = PH_IDLE;
          res_o.valid = 1'b1;
          res_o.code  = K_ESC;
          if (dir_ok) begin
            if (held_q == B_DIG5) begin
              res_o.code = K_CTRL_UP + dir_off;
            end else if (held_q == B_DIG2) begin
              res_o.code = K_SHIFT_UP + dir_off;
            end else if (held_q == B_DIG6 && dir_off == 5'd2) begin
              res_o.code = K_CS_RIGHT;
            end else if (held_q == B_DIG6 && dir_off == 5'd3) begin
              res_o.code = K_CS_LEFT;
            end
          end
        end
        default: begin
          // Idle, and any phase code without a meaning.
          phase_d     = PH_IDLE;
          res_o.valid = 1'b1;
          case (byte_i)
            B_CTRL_R: res_o.code = K_CTRL_R;
            B_CTRL_F: res_o.code = K_CTRL_F;
            B_CTRL_G: res_o.code = K_CTRL_G;
            B_CTRL_C: res_o.code = K_CTRL_C;
            B_CTRL_X: res_o.code = K_CTRL_X;
            B_CTRL_V: res_o.code = K_CTRL_V;
            B_CTRL_Z: res_o.code = K_CTRL_Z;
            B_CTRL_W: res_o.code = K_CTRL_W;
            B_DEL:    res_o.code = K_BS;
            B_BS:     res_o.code = K_BS;
            B_ESC: begin
              phase_d     = PH_ESC;
              res_o.valid = 1'b0;
            end
            default: begin
              res_o.code = K_PLAIN;
              res_o.ch   = byte_i;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

### src/tksd_out_reg.sv
// ----------------------------------------------------------------------------
// tksd_out_reg
// Result register that holds one key code until the receiver takes it.
// ----------------------------------------------------------------------------
module tksd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tksd_pkg::result_t res_i,
  input  logic              ready_i,
  output logic              free_o,
  output logic              valid_o,
  output logic [4:0]        code_o,
  output logic [7:0]        ch_o
);
  import tksd_pkg::*;

  logic       valid_q;
  logic [4:0] code_q;
  logic [7:0] ch_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign code_o  = code_q;
  assign ch_o    = ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_i.valid;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      code_q <= res_i.code;
      ch_q   <= res_i.ch;
    end
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terminal key sequence decoder. Directed keys and
// escape sequences come first, then a random stream of mostly well-formed
// sequences mixed with noise. Every key code is predicted in the bench and
// compared with what the block sends on its master stream.
// ----------------------------------------------------------------------------
module tb_top;
  import tksd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [4:0] code;
    logic [7:0] ch;
  } key_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;

  // Bench copy of the parser state.
  phase_e     parse_st = PH_IDLE;
  logic [7:0] held_q = 8'd0;

  key_event_t pending_keys[$];
  int         items_sent = 0;
  int         keys_checked = 0;
  int         sequences_sent = 0;
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;

  terminal_key_sequence_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .s_axis_tuser  (s_axis_tuser),   // [0] operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [4:0] key_code, [12:5] char_value
  );

  always #1 clk_i = ~clk_i;

  // Works out the key that one item produces and advances the bench parser.
  function automatic logic decode_key(input logic op, input logic [7:0] b,
                                      output key_event_t key);
    logic [7:0] h;
    logic [4:0] d;
    logic       is_dir;
    h = held_q;
    d = b[4:0] - B_UPA[4:0];
    is_dir = (b >= B_UPA) && (b <= B_UPD);
    key.code = K_ESC;
    key.ch = 8'd0;
    if (op == OP_TICK) begin
      if (parse_st == PH_ESC) begin
        parse_st = PH_IDLE;
        return 1'b1;
      end
      return 1'b0;
    end
    case (parse_st)
      PH_ESC: begin
        if (b == B_DEL || b == B_BS) begin
          parse_st = PH_IDLE;
          key.code = K_ALTBS;
          return 1'b1;
        end
        held_q = b;
        parse_st = PH_SEQ1;
        return 1'b0;
      end
      PH_SEQ1: begin
        parse_st = PH_IDLE;
        if (h == B_LBRACK) begin
          if (is_dir) begin
            key.code = K_UP + d;
            return 1'b1;
          end
          if (b >= B_DIG0 && b <= B_DIG9) begin
            held_q = b;
            parse_st = PH_SEQ2;
            return 1'b0;
          end
        end
        return 1'b1;
      end
      PH_SEQ2: begin
        parse_st = PH_IDLE;
        if (h == B_DIG3 && b == B_TILDE) begin
          key.code = K_DELETE;
        end else if (h == B_DIG2 && b == B_DIG0) begin
          parse_st = PH_PASTE3;
          return 1'b0;
        end else if (h == B_DIG1 && b == B_SEMI) begin
          parse_st = PH_MOD;
          return 1'b0;
        end
        return 1'b1;
      end
      PH_PASTE3: begin
        held_q = b;
        parse_st = PH_PASTE4;
        return 1'b0;
      end
      PH_PASTE4: begin
        parse_st = PH_IDLE;
        if (b == B_TILDE && h == B_DIG0) key.code = K_PSTART;
        else if (b == B_TILDE && h == B_DIG1) key.code = K_PEND;
        return 1'b1;
      end
      PH_MOD: begin
        held_q = b;
        parse_st = PH_DIR;
        return 1'b0;
      end
      PH_DIR: begin
        parse_st = PH_IDLE;
        if (is_dir) begin
          if (h == B_DIG5) key.code = K_CTRL_UP + d;
          else if (h == B_DIG2) key.code = K_SHIFT_UP + d;
          else if (h == B_DIG6 && d == 5'd2) key.code = K_CS_RIGHT;
          else if (h == B_DIG6 && d == 5'd3) key.code = K_CS_LEFT;
        end
        return 1'b1;
      end
      default: begin
        parse_st = PH_IDLE;
        case (b)
          B_CTRL_R: key.code = K_CTRL_R;
          B_CTRL_F: key.code = K_CTRL_F;
          B_CTRL_G: key.code = K_CTRL_G;
          B_CTRL_C: key.code = K_CTRL_C;
          B_CTRL_X: key.code = K_CTRL_X;
          B_CTRL_V: key.code = K_CTRL_V;
          B_CTRL_Z: key.code = K_CTRL_Z;
          B_CTRL_W: key.code = K_CTRL_W;
          B_DEL, B_BS: key.code = K_BS;
          B_ESC: begin
            parse_st = PH_ESC;
            return 1'b0;
          end
          default: begin
            key.code = K_PLAIN;
            key.ch = b;
          end
        endcase
        return 1'b1;
      end
    endcase
  endfunction

  // Offers one item and returns at the edge where its transfer happens.
  // The valid stays high afterwards so that back-to-back items need no gap.
  task automatic send_item(input logic op, input logic [7:0] b);
    int         gap;
    key_event_t key;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (decode_key(op, b, key)) pending_keys.push_back(key);
  endtask

  // Holds the sender off until every predicted key has come out.
  task automatic drain_keys();
    s_axis_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_single_keys();
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, B_CTRL_R);
    send_item(OP_BYTE, B_CTRL_F);
    send_item(OP_BYTE, B_CTRL_G);
    send_item(OP_BYTE, B_CTRL_C);
    send_item(OP_BYTE, B_CTRL_X);
    send_item(OP_BYTE, B_CTRL_V);
    send_item(OP_BYTE, B_CTRL_Z);
    send_item(OP_BYTE, B_CTRL_W);
    send_item(OP_BYTE, B_DEL);
    send_item(OP_BYTE, B_BS);
    // A tick with no sequence open produces nothing.
    send_item(OP_TICK, 8'hA5);
  endtask

  task automatic test_escape_directed();
    send_item(OP_BYTE, B_ESC);
    send_item(OP_TICK, 8'h5A);
    send_item(OP_BYTE, B_ESC);
    send_item(OP_BYTE, B_BS);
    // Paste start with a tick in the middle, which must be ignored.
    send_item(OP_BYTE, B_ESC);
    send_item(OP_BYTE, B_LBRACK);
    send_item(OP_BYTE, B_DIG2);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, B_DIG0);
    send_item(OP_BYTE, B_DIG0);
    send_item(OP_BYTE, B_TILDE);
  endtask

  // Sends one escape sequence with random content, sometimes corrupted or
  // with a tick slipped in among or after its bytes.
  task automatic send_key_sequence();
    logic [7:0] seq[$];
    int         tick_at;
    int         pos;
    seq = '{B_ESC};
    tick_at = -1;
    case ($urandom_range(0, 9))
      0: seq.push_back($urandom_range(0, 1) ? B_DEL : B_BS);
      1: tick_at = 1;
      2: seq = '{B_ESC, B_LBRACK, 8'(B_UPA + $urandom_range(0, 3))};
      3: seq = '{B_ESC, B_LBRACK, B_DIG3, B_TILDE};
      4: seq = '{B_ESC, B_LBRACK, B_DIG2, B_DIG0,
                 $urandom_range(0, 1) ? B_DIG1 : B_DIG0, B_TILDE};
      5, 6: begin
        seq = '{B_ESC, B_LBRACK, B_DIG1, B_SEMI};
        case ($urandom_range(0, 3))
          0: seq.push_back(B_DIG5);
          1: seq.push_back(B_DIG2);
          default: seq.push_back(B_DIG6);
        endcase
        seq.push_back(8'(B_UPA + $urandom_range(0, 3)));
      end
      7: seq = '{B_ESC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
      8: seq = '{B_ESC, B_LBRACK, 8'(B_DIG0 + $urandom_range(0, 9)),
                 8'($urandom_range(0, 255))};
      default: seq = '{B_ESC, B_LBRACK, B_DIG1, B_SEMI,
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    endcase
    if (seq.size() > 1 && $urandom_range(0, 7) == 0) begin
      pos = $urandom_range(1, seq.size() - 1);
      seq[pos] = 8'($urandom_range(0, 255));
    end
    if (tick_at < 0 && $urandom_range(0, 15) == 0) tick_at = $urandom_range(1, seq.size());
    for (int i = 0; i <= seq.size(); i++) begin
      if (i == tick_at) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      if (i < seq.size()) send_item(OP_BYTE, seq[i]);
    end
    sequences_sent++;
  endtask

  task automatic test_key_stream(input int n_items);
    int stop_at;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_key_sequence();
      end else if (pick < 65) begin
        case ($urandom_range(0, 9))
          0: send_item(OP_BYTE, B_CTRL_R);
          1: send_item(OP_BYTE, B_CTRL_F);
          2: send_item(OP_BYTE, B_CTRL_G);
          3: send_item(OP_BYTE, B_CTRL_C);
          4: send_item(OP_BYTE, B_CTRL_X);
          5: send_item(OP_BYTE, B_CTRL_V);
          6: send_item(OP_BYTE, B_CTRL_Z);
          7: send_item(OP_BYTE, B_CTRL_W);
          8: send_item(OP_BYTE, B_DEL);
          default: send_item(OP_BYTE, B_BS);
        endcase
      end else if (pick < 92) begin
        send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver: random stalls between keys, and the check of each transfer.
  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        keys_checked++;
        if (pending_keys.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected key, expected none, actual code %0d char 0x%02h",
                   $time, m_axis_tdata[4:0], m_axis_tdata[12:5]);
        end else begin
          want = pending_keys.pop_front();
          if (m_axis_tdata[4:0] !== want.code) begin
            mismatch_count++;
            $display("%0t: key_code mismatch, expected %0d actual %0d", $time,
                     want.code, m_axis_tdata[4:0]);
          end
          if (m_axis_tdata[12:5] !== want.ch) begin
            mismatch_count++;
            $display("%0t: char_value mismatch, expected 0x%02h actual 0x%02h", $time,
                     want.ch, m_axis_tdata[12:5]);
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_keys();
    test_escape_directed();
    drain_keys();
    calm = 1'b1;
    test_key_stream(150);
    calm = 1'b0;
    test_key_stream(500);
    drain_keys();
    test_key_stream(ITEM_TARGET - items_sent);
    s_axis_tvalid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d items, among them %0d escape sequences, some cut by ticks.",
             items_sent, sequences_sent);
    $display("Checked %0d key transfers with random stalls on both streams.", keys_checked);
    if (mismatch_count == 0 && pending_keys.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
src/tksd_pkg.sv
src/tksd_decode.sv
src/tksd_out_reg.sv
src/terminal_key_sequence_decoder.sv
test/tb_top.sv
